>>> rtl/pdtc_pkg.sv
// ----------------------------------------------------------------------------
// pdtc_pkg
// Shared widths, codes, coefficients, stage payload types and divide-by-ten
// helpers for the DIRECT-format telemetry converter.
// ----------------------------------------------------------------------------
package pdtc_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int Y_W        = 16;
	localparam int MODE_W     = 3;
	localparam int RS_W       = 12;
	localparam int K_W        = 14;
	localparam int VAL_W      = 32;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam int M_W   = 26;
	localparam int B_W   = 14;
	localparam int R_W   = 3;
	localparam int NUM_W = 27;
	localparam int MAG_W = 26;
	localparam int DEN_W = 22;
	localparam int REM_W = DEN_W + 1;
	localparam int Q_W   = 32;

	localparam int NORM_STAGES = 4;
	localparam int DIV_STEPS   = 2;
	localparam int DIV_STAGES  = Q_W / DIV_STEPS;

	localparam logic [CFG_IDX_W-1:0] CFG_CL_HIGH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RSENSE  = 1'd1;

	localparam logic [MODE_W-1:0] MODE_VIN  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_VOUT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TEMP = 3'd2;
	localparam logic [MODE_W-1:0] MODE_IIN  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PIN  = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_RSENSE = 2'd1,
		STAT_SAT       = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_CONV      = 2'd0,
		KIND_NO_RSENSE = 2'd1,
		KIND_UNUSED    = 2'd2
	} kind_t;

	// fixed coefficient sets
	localparam logic [M_W-1:0]        M_VOLT   = 26'd22070;
	localparam logic signed [B_W-1:0] B_VOLT   = -14'sd1800;
	localparam logic signed [R_W-1:0] R_VOLT   = -3'sd2;
	localparam logic [M_W-1:0]        M_TEMP   = 26'd16000;
	localparam logic signed [B_W-1:0] B_TEMP   = 14'sd0;
	localparam logic signed [R_W-1:0] R_TEMP   = -3'sd3;
	localparam logic signed [R_W-1:0] R_SCALED = -3'sd2;

	// sense-resistor scaled sets, slope is k * milliohms
	localparam logic [K_W-1:0]        K_IIN_LO = 14'd13661;
	localparam logic [K_W-1:0]        K_IIN_HI = 14'd6854;
	localparam logic [K_W-1:0]        K_PIN_LO = 14'd736;
	localparam logic [K_W-1:0]        K_PIN_HI = 14'd369;
	localparam logic signed [B_W-1:0] B_IIN_LO = -14'sd5200;
	localparam logic signed [B_W-1:0] B_IIN_HI = -14'sd3100;
	localparam logic signed [B_W-1:0] B_PIN_LO = -14'sd3300;
	localparam logic signed [B_W-1:0] B_PIN_HI = -14'sd1900;

	localparam logic [M_W-1:0] M_MAX = 26'd32767;

	localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

	// reciprocal constants for divide by ten
	localparam logic [M_W-1:0]   DIV10_K26 = 26'd53687092;
	localparam logic [B_W-2:0]   DIV10_K13 = 13'd6554;

	typedef struct packed {
		logic signed [Y_W-1:0] y;
		logic [M_W-1:0]        m;
		logic signed [B_W-1:0] b;
		logic signed [R_W-1:0] r;
		kind_t                 kind;
	} coef_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
		kind_t                   kind;
	} nd_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   acc;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic             ovf;
		kind_t            kind;
	} dvs_t;

	// floor(x / 10), exact for x below 2^26
	function automatic logic [M_W-1:0] div10_u26(input logic [M_W-1:0] x);
		logic [2*M_W-1:0] p;
		p = {{M_W{1'b0}}, x} * {{M_W{1'b0}}, DIV10_K26};
		return {3'b000, p[2*M_W-1:29]};
	endfunction

	// floor(x / 10), exact for x below 2^13
	function automatic logic [B_W-2:0] div10_u13(input logic [B_W-2:0] x);
		logic [2*(B_W-1)-1:0] p;
		p = {{(B_W-1){1'b0}}, x} * {{(B_W-1){1'b0}}, DIV10_K13};
		return {3'b000, p[2*(B_W-1)-1:16]};
	endfunction

	// (b + 5) / 10 truncated toward zero
	function automatic logic signed [B_W-1:0] bdiv10(input logic signed [B_W-1:0] b);
		logic signed [B_W-1:0] t;
		logic signed [B_W-1:0] nt;
		logic [B_W-2:0]        mag;
		logic [B_W-2:0]        q;
		t   = b + 14'sd5;
		nt  = -t;
		mag = t[B_W-1] ? nt[B_W-2:0] : t[B_W-2:0];
		q   = div10_u13(mag);
		return t[B_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

endpackage

>>> rtl/pdtc_coef.sv
// ----------------------------------------------------------------------------
// pdtc_coef
// Coefficient select with the slope multiply, then one register stage per
// normalization step (slope and offset divided by ten while slope > 32767).
// ----------------------------------------------------------------------------
module pdtc_coef (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cl_high,
	input  logic [pdtc_pkg::RS_W-1:0]     rsense,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pdtc_pkg::MODE_W-1:0]   in_mode,
	input  logic signed [pdtc_pkg::Y_W-1:0] in_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pdtc_pkg::coef_t               out_data
);
	import pdtc_pkg::*;

	localparam int LAST = NORM_STAGES;

	logic [K_W-1:0]   k_sel;
	logic [M_W-1:0]   slope;
	coef_t            sel_d;
	coef_t            cf_d [0:LAST];
	coef_t            cf_s [0:LAST];
	logic [LAST:0]    cf_vld_s;
	logic [LAST:0]    stg_rdy;

	function automatic coef_t norm_step(input coef_t c);
		coef_t o;
		o = c;
		if (c.m > M_MAX) begin
			o.m = div10_u26(c.m + 26'd5);
			o.b = bdiv10(c.b);
			o.r = c.r + 3'sd1;
		end
		return o;
	endfunction

	always_comb begin
		if (in_mode == MODE_PIN) begin
			k_sel = cl_high ? K_PIN_HI : K_PIN_LO;
		end else begin
			k_sel = cl_high ? K_IIN_HI : K_IIN_LO;
		end
	end

	assign slope = M_W'(k_sel) * M_W'(rsense);

	always_comb begin
		sel_d      = '0;
		sel_d.y    = in_y;
		sel_d.r    = R_SCALED;
		sel_d.kind = KIND_CONV;
		unique case (in_mode)
			MODE_VIN, MODE_VOUT: begin
				sel_d.m = M_VOLT;
				sel_d.b = B_VOLT;
				sel_d.r = R_VOLT;
			end
			MODE_TEMP: begin
				sel_d.m = M_TEMP;
				sel_d.b = B_TEMP;
				sel_d.r = R_TEMP;
			end
			MODE_IIN: begin
				sel_d.m = slope;
				sel_d.b = cl_high ? B_IIN_HI : B_IIN_LO;
				if (rsense == '0) sel_d.kind = KIND_NO_RSENSE;
			end
			MODE_PIN: begin
				sel_d.m = slope;
				sel_d.b = cl_high ? B_PIN_HI : B_PIN_LO;
				if (rsense == '0) sel_d.kind = KIND_NO_RSENSE;
			end
			default: begin
				sel_d.kind = KIND_UNUSED;
			end
		endcase
	end

	assign cf_d[0] = sel_d;
	for (genvar i = 1; i <= LAST; i++) begin : g_norm
		assign cf_d[i] = norm_step(cf_s[i-1]);
	end

	always_comb begin
		stg_rdy[LAST] = !cf_vld_s[LAST] || out_ready;
		for (int i = LAST - 1; i >= 0; i--) begin
			stg_rdy[i] = !cf_vld_s[i] || stg_rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cf_vld_s <= '0;
		end else begin
			if (stg_rdy[0]) cf_vld_s[0] <= in_valid;
			for (int i = 1; i <= LAST; i++) begin
				if (stg_rdy[i]) cf_vld_s[i] <= cf_vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i <= LAST; i++) begin
			if (stg_rdy[i]) cf_s[i] <= cf_d[i];
		end
	end

	assign in_ready  = stg_rdy[0];
	assign out_valid = cf_vld_s[LAST];
	assign out_data  = cf_s[LAST];

endmodule

>>> rtl/pdtc_num.sv
// ----------------------------------------------------------------------------
// pdtc_num
// Builds numerator and denominator from the decimal exponent, then takes the
// magnitude, scales it by the fraction bits and checks quotient overflow.
// ----------------------------------------------------------------------------
module pdtc_num #(
	parameter int FRAC_BITS = pdtc_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pdtc_pkg::coef_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pdtc_pkg::dvs_t    out_data
);
	import pdtc_pkg::*;

	localparam int DVD_W = MAG_W + FRAC_BITS;

	nd_t                     nd_d;
	nd_t                     nd_s1;
	logic                    nd_vld_s1;
	dvs_t                    dv_d;
	dvs_t                    dv_s2;
	logic                    dv_vld_s2;
	logic                    rdy1;
	logic                    rdy2;

	logic signed [NUM_W-1:0] ys;
	logic signed [NUM_W-1:0] bs;
	logic [DEN_W-1:0]        mden;
	logic signed [NUM_W-1:0] absn;
	logic [MAG_W-1:0]        mag;
	logic [DVD_W-1:0]        dvd;
	logic [REM_W-1:0]        hi;
	logic                    ovf;

	// stage 1: num = y*10^-r - b, den = m for r <= 0; num = y - b*10^r, den = m*10^r
	always_comb begin
		ys          = NUM_W'(in_data.y);
		bs          = NUM_W'(in_data.b);
		mden        = DEN_W'(in_data.m);
		nd_d.kind   = in_data.kind;
		nd_d.den    = mden;
		unique case (in_data.r)
			-3'sd3:  nd_d.num = ys * 27'sd1000 - bs;
			-3'sd2:  nd_d.num = ys * 27'sd100 - bs;
			-3'sd1:  nd_d.num = ys * 27'sd10 - bs;
			3'sd1: begin
				nd_d.num = ys - bs * 27'sd10;
				nd_d.den = mden * 22'd10;
			end
			3'sd2: begin
				nd_d.num = ys - bs * 27'sd100;
				nd_d.den = mden * 22'd100;
			end
			default: nd_d.num = ys - bs;
		endcase
	end

	// stage 2: magnitude, fraction scaling, overflow when quotient needs 33+ bits
	always_comb begin
		absn = nd_s1.num[NUM_W-1] ? -nd_s1.num : nd_s1.num;
		mag  = absn[MAG_W-1:0];
		dvd  = {mag, {FRAC_BITS{1'b0}}};
		hi   = REM_W'(dvd >> Q_W);
		ovf  = hi >= {1'b0, nd_s1.den};

		dv_d.rem  = ovf ? '0 : hi;
		dv_d.acc  = dvd[Q_W-1:0];
		dv_d.den  = nd_s1.den;
		dv_d.neg  = nd_s1.num[NUM_W-1];
		dv_d.ovf  = ovf;
		dv_d.kind = nd_s1.kind;
	end

	assign rdy2 = !dv_vld_s2 || out_ready;
	assign rdy1 = !nd_vld_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_vld_s1 <= 1'b0;
			dv_vld_s2 <= 1'b0;
		end else begin
			if (rdy1) nd_vld_s1 <= in_valid;
			if (rdy2) dv_vld_s2 <= nd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) nd_s1 <= nd_d;
		if (rdy2) dv_s2 <= dv_d;
	end

	assign in_ready  = rdy1;
	assign out_valid = dv_vld_s2;
	assign out_data  = dv_s2;

endmodule

>>> rtl/pdtc_div.sv
// ----------------------------------------------------------------------------
// pdtc_div
// Pipelined restoring divider on the magnitude, a fixed number of quotient
// bits per stage; quotient bits shift into the low dividend word.
// ----------------------------------------------------------------------------
module pdtc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pdtc_pkg::dvs_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pdtc_pkg::dvs_t    out_data
);
	import pdtc_pkg::*;

	localparam int LAST = DIV_STAGES - 1;

	dvs_t          dv_d [0:LAST];
	dvs_t          dv_s [0:LAST];
	logic [LAST:0] dv_vld_s;
	logic [LAST:0] stg_rdy;

	function automatic dvs_t div_step(input dvs_t x);
		dvs_t             o;
		logic [REM_W-1:0] sh;
		logic [REM_W-1:0] dz;
		o  = x;
		dz = {1'b0, x.den};
		sh = {x.rem[REM_W-2:0], x.acc[Q_W-1]};
		if (sh >= dz) begin
			o.rem = sh - dz;
			o.acc = {x.acc[Q_W-2:0], 1'b1};
		end else begin
			o.rem = sh;
			o.acc = {x.acc[Q_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic dvs_t stage_work(input dvs_t x);
		dvs_t t;
		t = x;
		for (int k = 0; k < DIV_STEPS; k++) begin
			t = div_step(t);
		end
		return t;
	endfunction

	assign dv_d[0] = stage_work(in_data);
	for (genvar i = 1; i <= LAST; i++) begin : g_stage
		assign dv_d[i] = stage_work(dv_s[i-1]);
	end

	always_comb begin
		stg_rdy[LAST] = !dv_vld_s[LAST] || out_ready;
		for (int i = LAST - 1; i >= 0; i--) begin
			stg_rdy[i] = !dv_vld_s[i] || stg_rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s <= '0;
		end else begin
			if (stg_rdy[0]) dv_vld_s[0] <= in_valid;
			for (int i = 1; i <= LAST; i++) begin
				if (stg_rdy[i]) dv_vld_s[i] <= dv_vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i <= LAST; i++) begin
			if (stg_rdy[i]) dv_s[i] <= dv_d[i];
		end
	end

	assign in_ready  = stg_rdy[0];
	assign out_valid = dv_vld_s[LAST];
	assign out_data  = dv_s[LAST];

endmodule

>>> rtl/pmbus_direct_telemetry_convert.sv
// depth: 24 register stages between the edge that takes a transaction on s_axis and m_axis
// throughput: one transaction per cycle while m_axis is not stalled; 5 coefficient stages, 2 numerator stages,
// 16 divider stages of two quotient bits each and the output register set the depth
// a stalled m_axis only blocks s_axis once every stage holds a transaction
// reset: arst_n clears all stage valids, cl_high and the sense resistance (none fitted)
// ----------------------------------------------------------------------------
// pmbus_direct_telemetry_convert
// Converts DIRECT-format telemetry words to signed fixed point with
// saturation, using fixed or sense-resistor derived coefficients.
// ----------------------------------------------------------------------------
module pmbus_direct_telemetry_convert #(
	parameter int FRAC_BITS = pdtc_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [pdtc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pdtc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [pdtc_pkg::Y_W-1:0]          s_axis_tdata,  // [15:0] raw_word
	input  logic [pdtc_pkg::MODE_W-1:0]       s_axis_tuser,  // [2:0] mode
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [pdtc_pkg::VAL_W-1:0]        m_axis_tdata,  // [31:0] value
	output logic [pdtc_pkg::STAT_W-1:0]       m_axis_tuser   // [1:0] status
);
	import pdtc_pkg::*;

	logic             cl_high_q;
	logic [RS_W-1:0]  rsense_q;

	coef_t            cf_out;
	logic             cf_vld;
	logic             cf_rdy;
	dvs_t             nm_out;
	logic             nm_vld;
	logic             nm_rdy;
	dvs_t             dv_out;
	logic             dv_vld;
	logic             res_rdy;

	logic [VAL_W-1:0] val_d;
	status_t          stat_d;
	logic             res_vld_q;
	logic [VAL_W-1:0] res_value_q;
	status_t          res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cl_high_q <= 1'b0;
			rsense_q  <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				CFG_CL_HIGH: cl_high_q <= cfg_data[0];
				CFG_RSENSE:  rsense_q  <= cfg_data;
			endcase
		end
	end

	pdtc_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cl_high   (cl_high_q),
		.rsense    (rsense_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_y      ($signed(s_axis_tdata)),
		.out_valid (cf_vld),
		.out_ready (cf_rdy),
		.out_data  (cf_out)
	);

	pdtc_num #(
		.FRAC_BITS (FRAC_BITS)
	) u_num (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cf_vld),
		.in_ready  (cf_rdy),
		.in_data   (cf_out),
		.out_valid (nm_vld),
		.out_ready (nm_rdy),
		.out_data  (nm_out)
	);

	pdtc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nm_vld),
		.in_ready  (nm_rdy),
		.in_data   (nm_out),
		.out_valid (dv_vld),
		.out_ready (res_rdy),
		.out_data  (dv_out)
	);

	// sign restore and clamp to the signed 32-bit range; unused modes and a missing sense resistor give zero
	always_comb begin
		val_d  = '0;
		stat_d = STAT_OK;
		unique case (dv_out.kind)
			KIND_NO_RSENSE: stat_d = STAT_NO_RSENSE;
			KIND_UNUSED:    stat_d = STAT_OK;
			KIND_CONV: begin
				priority if (dv_out.ovf) begin
					val_d  = dv_out.neg ? VAL_MIN : VAL_MAX;
					stat_d = STAT_SAT;
				end else if (dv_out.neg) begin
					if (dv_out.acc > VAL_MIN) begin
						val_d  = VAL_MIN;
						stat_d = STAT_SAT;
					end else begin
						val_d = -dv_out.acc;
					end
				end else if (dv_out.acc[Q_W-1]) begin
					val_d  = VAL_MAX;
					stat_d = STAT_SAT;
				end else begin
					val_d = dv_out.acc;
				end
			end
			default: stat_d = STAT_OK;
		endcase
	end

	assign res_rdy = !res_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_rdy) begin
			res_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_rdy) begin
			res_value_q  <= val_d;
			res_status_q <= stat_d;
		end
	end

	assign m_axis_tvalid = res_vld_q;
	assign m_axis_tdata  = res_value_q;
	assign m_axis_tuser  = res_status_q;

	a_nores_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STAT_NO_RSENSE) |-> (m_axis_tdata == '0))
		else $error("missing sense resistor result carries a nonzero value");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STAT_SAT) |->
		(m_axis_tdata == VAL_MAX) || (m_axis_tdata == VAL_MIN))
		else $error("saturated result is not at a 32-bit limit");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input blocked while the output side is not stalled");

endmodule

>>> tb/tb_pmbus_direct_telemetry_convert.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pmbus_direct_telemetry_convert
// Streams raw DIRECT-format telemetry words through the converter under a
// range of current-limit and sense-resistor settings and compares every
// converted value and status against an integer prediction of the
// coefficient normalization, fixed-point division and saturation.
// ----------------------------------------------------------------------------
module tb_pmbus_direct_telemetry_convert;
	import pdtc_pkg::*;

	localparam int     FRAC   = 16;
	localparam longint VAL_HI = 64'sh7fff_ffff;
	localparam longint VAL_LO = -64'sh8000_0000;

	typedef struct {
		logic [VAL_W-1:0] value;
		status_t          status;
	} reading_t;

	class telemetry_checker;
		logic                  cl_high;
		logic [RS_W-1:0]       rsense;
		reading_t              expected_readings[$];
		int                    errors;
		int                    checked;
		int                    n_sat;
		int                    n_no_rsense;

		function new();
			cl_high     = 1'b0;
			rsense      = '0;
			errors      = 0;
			checked     = 0;
			n_sat       = 0;
			n_no_rsense = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_CL_HIGH: cl_high = data[0];
				CFG_RSENSE:  rsense  = data[RS_W-1:0];
				default: ;
			endcase
		endfunction

		// X = (Y*10^-R - B) / M in fixed point, truncated and clamped to 32 bits
		function reading_t convert_word(logic [MODE_W-1:0] mode, logic signed [Y_W-1:0] raw);
			reading_t res;
			longint   y;
			longint   m;
			longint   b;
			longint   num;
			longint   den;
			longint   q;
			longint   scale;
			int       r;
			int       mag;
			y          = raw;
			res.value  = '0;
			res.status = STAT_OK;
			case (mode)
				MODE_VIN, MODE_VOUT: begin
					m = 22070;
					b = -1800;
					r = -2;
				end
				MODE_TEMP: begin
					m = 16000;
					b = 0;
					r = -3;
				end
				MODE_IIN, MODE_PIN: begin
					if (rsense == 0) begin
						res.status = STAT_NO_RSENSE;
						return res;
					end
					if (mode == MODE_IIN) begin
						m = (cl_high ? 6854 : 13661) * longint'(rsense);
						b = cl_high ? -3100 : -5200;
					end else begin
						m = (cl_high ? 369 : 736) * longint'(rsense);
						b = cl_high ? -1900 : -3300;
					end
					r = -2;
					// slope must fit 16 bits signed, so trade decades into the exponent
					while (m > 32767) begin
						m = (m + 5) / 10;
						b = (b + 5) / 10;
						r = r + 1;
					end
				end
				default: return res;
			endcase
			mag   = (r < 0) ? -r : r;
			scale = 1;
			for (int i = 0; i < mag; i++)
				scale = scale * 10;
			if (r <= 0) begin
				num = y * scale - b;
				den = m;
			end else begin
				num = y - b * scale;
				den = m * scale;
			end
			q = (num * (64'sd1 << FRAC)) / den;
			if (q > VAL_HI) begin
				res.value  = VAL_MAX;
				res.status = STAT_SAT;
			end else if (q < VAL_LO) begin
				res.value  = VAL_MIN;
				res.status = STAT_SAT;
			end else begin
				res.value = q[VAL_W-1:0];
			end
			return res;
		endfunction

		function void note_word(logic [MODE_W-1:0] mode, logic [Y_W-1:0] raw);
			reading_t res;
			res = convert_word(mode, raw);
			if (res.status == STAT_SAT)
				n_sat++;
			if (res.status == STAT_NO_RSENSE)
				n_no_rsense++;
			expected_readings.push_back(res);
		endfunction

		task report_mismatch(string msg);
			if (errors < 40)
				$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [VAL_W-1:0] value, logic [STAT_W-1:0] status);
			reading_t exp_res;
			if (expected_readings.size() == 0) begin
				report_mismatch($sformatf("result %h status %0d with no conversion pending",
					value, status));
				return;
			end
			exp_res = expected_readings.pop_front();
			if (value !== exp_res.value)
				report_mismatch($sformatf("value %h, predicted %h", value, exp_res.value));
			if (status !== exp_res.status)
				report_mismatch($sformatf("status %0d, predicted %0d", status, exp_res.status));
			checked++;
		endtask

		function int pending();
			return expected_readings.size();
		endfunction
	endclass

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wen       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx       = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [Y_W-1:0]        s_axis_tdata  = '0;   // [15:0] raw_word
	logic [MODE_W-1:0]     s_axis_tuser  = '0;   // [2:0] mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [VAL_W-1:0]      m_axis_tdata;         // [31:0] value
	logic [STAT_W-1:0]     m_axis_tuser;         // [1:0] status

	telemetry_checker sb;
	int               send_idle_pct  = 0;
	int               recv_stall_pct = 0;
	int               n_settings     = 0;

	pmbus_direct_telemetry_convert #(
		.FRAC_BITS(FRAC)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_word(s_axis_tuser, s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// holds valid until the transaction is taken
	task automatic send_word(input logic [MODE_W-1:0] mode, input logic [Y_W-1:0] raw);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= raw;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic apply_config(input logic cl, input logic [CFG_DATA_W-1:0] rs);
		logic [CFG_DATA_W-1:0] cl_word;
		cl_word    = CFG_DATA_W'($urandom);
		cl_word[0] = cl;
		cfg_wen  <= 1'b1;
		cfg_idx  <= CFG_CL_HIGH;
		cfg_data <= cl_word;
		@(posedge clk);
		sb.set_reg(CFG_CL_HIGH, cl_word);
		cfg_idx  <= CFG_RSENSE;
		cfg_data <= rs;
		@(posedge clk);
		sb.set_reg(CFG_RSENSE, rs);
		cfg_wen <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic                  cl;
		logic [CFG_DATA_W-1:0] rs;
		logic [MODE_W-1:0]     mode;
		logic [Y_W-1:0]        raw;

		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no sense resistor: fixed channels at their extremes and at zero, scaled ones flag, then unused modes
		apply_config(1'b0, '0);
		send_word(MODE_VIN, 16'h7fff);
		send_word(MODE_VIN, 16'h8000);
		send_word(MODE_VOUT, 16'h0000);
		send_word(MODE_TEMP, 16'h7fff);
		send_word(MODE_TEMP, 16'h8000);
		send_word(MODE_IIN, 16'd100);
		send_word(MODE_PIN, 16'hffff);
		send_word(3'd5, Y_W'($urandom));
		send_word(3'd6, Y_W'($urandom));
		send_word(3'd7, Y_W'($urandom));
		s_axis_tvalid <= 1'b0;
		wait_drained();

		// tiny slope on power gives the largest magnitudes both ways
		apply_config(1'b1, 12'd1);
		send_word(MODE_PIN, 16'h7fff);
		send_word(MODE_PIN, 16'h8000);
		send_word(MODE_IIN, 16'h7fff);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		// largest resistance pushes the exponent positive
		apply_config(1'b0, 12'd4095);
		send_word(MODE_IIN, 16'h7fff);
		send_word(MODE_IIN, 16'h8000);
		send_word(MODE_PIN, 16'h7fff);
		send_word(MODE_PIN, 16'h8000);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		apply_config(1'b1, 12'd4095);
		send_word(MODE_IIN, 16'h8000);
		send_word(MODE_PIN, 16'h0000);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		for (int seg = 0; seg < 10; seg++) begin
			case (seg)
				0: begin cl = 1'b0; rs = 12'd4095; end
				1: begin cl = 1'b1; rs = 12'd1; end
				2: begin cl = 1'b0; rs = '0; end
				3: begin cl = 1'b1; rs = 12'd4095; end
				default: begin
					cl = 1'($urandom_range(1));
					case ($urandom_range(3))
						0: rs = CFG_DATA_W'($urandom_range(12, 1));
						1: rs = CFG_DATA_W'(4095 - $urandom_range(20));
						default: rs = CFG_DATA_W'($urandom_range(4095));
					endcase
				end
			endcase
			case (seg % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			apply_config(cl, rs);
			for (int i = 0; i < 65; i++) begin
				if ($urandom_range(9) == 0)
					mode = MODE_W'($urandom_range(7, 5));
				else
					mode = MODE_W'($urandom_range(4));
				if ($urandom_range(3) == 0) begin
					case ($urandom_range(3))
						0: raw = 16'h7fff;
						1: raw = 16'h8000;
						2: raw = 16'h0000;
						default: raw = 16'hffff;
					endcase
				end else begin
					raw = Y_W'($urandom);
				end
				send_word(mode, raw);
			end
			s_axis_tvalid <= 1'b0;
			wait_drained();
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (40) @(posedge clk);
		$display("%0d words converted over %0d coefficient settings", sb.checked, n_settings);
		$display("%0d saturated, %0d flagged without sense resistor, %0d mismatches",
			sb.n_sat, sb.n_no_rsense, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d conversions outstanding", sb.pending());
		$display("== FAIL ==");
		$finish;
	end

endmodule
